// ===== rtl/aoc_pkg.sv =====
package aoc_pkg;

  localparam int unsigned ValW = 12;
  localparam int unsigned AccW = 16;
  localparam int unsigned OffW = 11;
  localparam int unsigned CntW = 8;
  localparam int unsigned MapW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned NumAxes = 3;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [AccW-1:0] acc_t;
  typedef val_t [NumAxes-1:0] trio_t;
  typedef acc_t [NumAxes-1:0] acc_trio_t;
  typedef logic [MapW-1:0] map_t;
  typedef map_t [NumAxes-1:0] map_trio_t;

  typedef enum logic [1:0] {
    RANGE_8G  = 2'd0,
    RANGE_2G  = 2'd1,
    RANGE_4G  = 2'd2,
    RANGE_BAD = 2'd3
  } range_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_REJECT  = 3'd1,
    ST_UPDATED = 3'd2,
    ST_DONE    = 3'd3,
    ST_FAILED  = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANGE    = 3'd0,
    CFG_MAP_X    = 3'd1,
    CFG_MAP_Y    = 3'd2,
    CFG_MAP_Z    = 3'd3,
    CFG_OVERRUN  = 3'd4,
    CFG_FUZZ     = 3'd5,
    CFG_ONE_G    = 3'd6,
    CFG_MAX_ATT  = 3'd7
  } cfg_idx_e;

  // map codes: +x, -x, +y, -y, +z, -z; above MAP_LAST selects nothing
  localparam map_t MAP_POS_X = 3'd0;
  localparam map_t MAP_NEG_X = 3'd1;
  localparam map_t MAP_POS_Y = 3'd2;
  localparam map_t MAP_NEG_Y = 3'd3;
  localparam map_t MAP_POS_Z = 3'd4;
  localparam map_t MAP_NEG_Z = 3'd5;
  localparam map_t MAP_LAST  = 3'd5;

  typedef struct packed {
    logic fresh;    // beat starts a new calibration
    logic clr_en;   // write zero to the accumulator
    logic load_en;  // write the updated sum
  } lane_ctl_t;

  typedef struct packed {
    logic pass;
    acc_t sum_nxt;
  } lane_res_t;

  typedef struct packed {
    status_e           status;
    logic [OffW-1:0]   off_x;
    logic [OffW-1:0]   off_y;
    logic [OffW-1:0]   off_z;
    logic [CntW-1:0]   attempts;
  } out_beat_t;

  function automatic val_t decode(input logic [9:0] raw, input range_e mode);
    val_t v;
    if (mode == RANGE_8G) begin
      v = {{(ValW-10){raw[9]}}, raw};
    end else begin
      v = {{(ValW-8){raw[7]}}, raw[7:0]};
      if (mode == RANGE_4G) begin
        v = v <<< 1;
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/aoc_lane.sv =====
module aoc_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aoc_pkg::trio_t     samp_i,
  input  aoc_pkg::map_t      code_i,
  input  logic [8:0]         target_i,
  input  logic [6:0]         fuzz_i,
  input  aoc_pkg::lane_ctl_t ctl_i,
  output aoc_pkg::lane_res_t res_o
);
  import aoc_pkg::*;

  acc_t sum_q, sum_d;
  acc_t base;
  val_t r, tgt, lo, hi, delta;

  always_comb begin
    unique case (code_i)
      MAP_POS_X: r = samp_i[0];
      MAP_NEG_X: r = -samp_i[0];
      MAP_POS_Y: r = samp_i[1];
      MAP_NEG_Y: r = -samp_i[1];
      MAP_POS_Z: r = samp_i[2];
      MAP_NEG_Z: r = -samp_i[2];
      default:   r = '0;
    endcase
  end

  assign tgt   = val_t'({3'b000, target_i});
  assign lo    = tgt - val_t'({5'b00000, fuzz_i});
  assign hi    = tgt + val_t'({5'b00000, fuzz_i});
  assign delta = tgt - r;
  assign base  = ctl_i.fresh ? '0 : sum_q;

  assign res_o.pass    = (r > lo) && (r < hi);
  assign res_o.sum_nxt = base + {{(AccW-ValW){delta[ValW-1]}}, delta};

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.load_en) begin
      sum_d = res_o.sum_nxt;
    end else if (ctl_i.clr_en) begin
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

// ===== rtl/aoc_merge.sv =====
module aoc_merge (
  input  aoc_pkg::map_trio_t               codes_i,
  input  aoc_pkg::lane_res_t [2:0]         lanes_i,
  input  aoc_pkg::acc_trio_t               base_i,
  output aoc_pkg::acc_trio_t               unmapped_o,
  output logic                             all_pass_o
);
  import aoc_pkg::*;

  // later board axis wins when two lanes name the same sensor axis
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      unmapped_o[a] = base_i[a];
      for (int b = 0; b < NumAxes; b++) begin
        if (codes_i[b] <= MAP_LAST && codes_i[b][2:1] == 2'(a)) begin
          unmapped_o[a] = codes_i[b][0] ? -lanes_i[b].sum_nxt : lanes_i[b].sum_nxt;
        end
      end
    end
  end

  assign all_pass_o = lanes_i[0].pass & lanes_i[1].pass & lanes_i[2].pass;

endmodule

// ===== rtl/accel_offset_calibration.sv =====
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_stall_o  | start_req, data_ready, overrun, raw_x/y/z
// out     | out | out_valid_o/out_stall_i| status, offset_x/y/z, attempts
// cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle unless in_stall_o is high; results are registered.
// Three axis lanes and the merge settle the state in the accepting cycle.
// Output register plus one skid entry; in_stall_o rises only when both hold.
// Reset is asynchronous, active low, and restores the default configuration.
module accel_offset_calibration (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic        data_ready_i,
  input  logic        overrun_i,
  input  logic [9:0]  raw_x_i,
  input  logic [9:0]  raw_y_i,
  input  logic [9:0]  raw_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [10:0] offset_x_o,
  output logic [10:0] offset_y_o,
  output logic [10:0] offset_z_o,
  output logic [7:0]  attempts_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);
  import aoc_pkg::*;

  range_e         range_q;
  map_trio_t      map_q;
  logic           chk_q;
  logic [6:0]     fuzz_q;
  logic [8:0]     one_g_q;
  logic [CntW-1:0] max_q;

  logic           cal_q, cal_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  acc_trio_t      unm_q, unm_d;

  out_beat_t      out_q, skid_q, beat;
  logic           out_valid_q, skid_valid_q;

  logic           acc, cal_eff, rej, fail, done, upd, all_pass;
  logic [CntW-1:0] cnt_eff, cnt_bump;
  acc_trio_t      unm_base, unm_new;
  trio_t          samp;
  lane_ctl_t      ctl;
  lane_res_t [2:0] lanes;
  status_e        status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_4G;
      map_q   <= {MAP_NEG_Z, MAP_POS_Y, MAP_POS_X};
      chk_q   <= 1'b1;
      fuzz_q  <= 7'd3;
      one_g_q <= 9'd64;
      max_q   <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE:   range_q  <= range_e'(cfg_wdata_i[1:0]);
        CFG_MAP_X:   map_q[0] <= cfg_wdata_i[2:0];
        CFG_MAP_Y:   map_q[1] <= cfg_wdata_i[2:0];
        CFG_MAP_Z:   map_q[2] <= cfg_wdata_i[2:0];
        CFG_OVERRUN: chk_q    <= cfg_wdata_i[0];
        CFG_FUZZ:    fuzz_q   <= cfg_wdata_i[6:0];
        CFG_ONE_G:   one_g_q  <= cfg_wdata_i;
        CFG_MAX_ATT: max_q    <= cfg_wdata_i[7:0];
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign acc        = in_valid_i & ~in_stall_o;

  assign samp[0] = decode(raw_x_i, range_q);
  assign samp[1] = decode(raw_y_i, range_q);
  assign samp[2] = decode(raw_z_i, range_q);

  assign cal_eff  = start_req_i | cal_q;
  assign cnt_eff  = start_req_i ? '0 : cnt_q;
  assign cnt_bump = (cnt_eff == '1) ? cnt_eff : cnt_eff + 1'b1;
  assign unm_base = start_req_i ? '0 : unm_q;

  assign rej  = ~data_ready_i | (range_q == RANGE_BAD) | (chk_q & overrun_i);
  assign fail = cal_eff & (cnt_eff > max_q);
  assign done = cal_eff & ~fail & ~rej & all_pass;
  assign upd  = cal_eff & ~fail & ~rej & ~all_pass;

  assign ctl.fresh   = start_req_i;
  assign ctl.clr_en  = acc & start_req_i;
  assign ctl.load_en = acc & upd;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    aoc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .samp_i   (samp),
      .code_i   (map_q[g]),
      .target_i ((g == NumAxes - 1) ? one_g_q : 9'd0),
      .fuzz_i   (fuzz_q),
      .ctl_i    (ctl),
      .res_o    (lanes[g])
    );
  end

  aoc_merge u_merge (
    .codes_i    (map_q),
    .lanes_i    (lanes),
    .base_i     (unm_base),
    .unmapped_o (unm_new),
    .all_pass_o (all_pass)
  );

  always_comb begin
    status = ST_IDLE;
    cal_d  = cal_eff;
    cnt_d  = cnt_eff;
    unm_d  = unm_base;
    if (fail) begin
      status = ST_FAILED;
      cal_d  = 1'b0;
    end else if (cal_eff & rej) begin
      status = ST_REJECT;
      cnt_d  = cnt_bump;
    end else if (done) begin
      status = ST_DONE;
      cal_d  = 1'b0;
    end else if (upd) begin
      status = ST_UPDATED;
      cnt_d  = cnt_bump;
      unm_d  = unm_new;
    end
  end

  assign beat.status   = status;
  assign beat.off_x    = unm_d[0][OffW-1:0];
  assign beat.off_y    = unm_d[1][OffW-1:0];
  assign beat.off_z    = unm_d[2][OffW-1:0];
  assign beat.attempts = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= 1'b0;
      cnt_q <= '0;
      unm_q <= '0;
    end else if (acc) begin
      cal_q <= cal_d;
      cnt_q <= cnt_d;
      unm_q <= unm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (acc) begin
      if (out_valid_q && out_stall_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (acc) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= beat;
      end else begin
        out_q <= beat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign offset_x_o  = out_q.off_x;
  assign offset_y_o  = out_q.off_y;
  assign offset_z_o  = out_q.off_z;
  assign attempts_o  = out_q.attempts;

endmodule

// ===== rtl/aoc_checker.sv =====
module aoc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [10:0] offset_x_o,
  input logic [10:0] offset_y_o,
  input logic [10:0] offset_z_o,
  input logic [7:0]  attempts_o
);
  import aoc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(offset_x_o) && $stable(offset_y_o) && $stable(offset_z_o) &&
      $stable(attempts_o))
    else $error("stalled output beat changed");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no output");

  a_stall_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_REJECT || status_o == ST_UPDATED) |->
      attempts_o != 8'd0)
    else $error("attempt beat with zero count");

endmodule

bind accel_offset_calibration aoc_checker u_aoc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .offset_x_o  (offset_x_o),
  .offset_y_o  (offset_y_o),
  .offset_z_o  (offset_z_o),
  .attempts_o  (attempts_o)
);

// ===== test/testbench.sv =====
module testbench;
  import aoc_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic start_req_i;
  logic data_ready_i;
  logic overrun_i;
  logic [9:0] raw_x_i;
  logic [9:0] raw_y_i;
  logic [9:0] raw_z_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [10:0] offset_x_o;
  logic [10:0] offset_y_o;
  logic [10:0] offset_z_o;
  logic [7:0] attempts_o;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [8:0] cfg_wdata_i;

  accel_offset_calibration dut (.*);

  // predictor copy of the configuration, at reset values
  range_e cfg_range = RANGE_4G;
  map_t cfg_map [3] = '{MAP_POS_X, MAP_POS_Y, MAP_NEG_Z};
  logic cfg_check_ovr = 1'b1;
  logic [6:0] cfg_fuzz = 7'd3;
  logic [8:0] cfg_one_g = 9'd64;
  logic [7:0] cfg_max_att = 8'd20;

  // predictor copy of the calibration state
  logic calibrating = 1'b0;
  logic [7:0] attempt_cnt = 8'd0;
  acc_t sums [3] = '{16'd0, 16'd0, 16'd0};
  acc_t unmapped [3] = '{16'd0, 16'd0, 16'd0};

  out_beat_t offsets_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("accel_offset_calibration: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off = hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (offsets_due.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = offsets_due.pop_front();
        check_field("status", want.status, status_o);
        check_field("offset_x", want.off_x, offset_x_o);
        check_field("offset_y", want.off_y, offset_y_o);
        check_field("offset_z", want.off_z, offset_z_o);
        check_field("attempts", want.attempts, attempts_o);
      end
    end
  end

  function automatic int decode_axis(logic [9:0] raw, range_e mode);
    int v;
    if (mode == RANGE_8G) begin
      v = raw[9] ? int'(raw) - 1024 : int'(raw);
    end else begin
      v = raw[7] ? int'(raw[7:0]) - 256 : int'(raw[7:0]);
      if (mode == RANGE_4G) begin
        v = 2 * v;
      end
    end
    return v;
  endfunction

  task automatic calibrate_step(input logic start, input logic ready, input logic ovr,
                                input logic [9:0] x, input logic [9:0] y,
                                input logic [9:0] z);
    out_beat_t res;
    logic [9:0] raws [3];
    int sens [3];
    int board [3];
    int f;
    int g;
    map_t c;
    status_e st;
    st = ST_IDLE;
    raws[0] = x;
    raws[1] = y;
    raws[2] = z;
    if (start) begin
      calibrating = 1'b1;
      attempt_cnt = 8'd0;
      for (int i = 0; i < 3; i++) begin
        sums[i] = '0;
        unmapped[i] = '0;
      end
    end
    if (calibrating) begin
      if (attempt_cnt > cfg_max_att) begin
        st = ST_FAILED;
        calibrating = 1'b0;
      end else if (!ready || cfg_range == RANGE_BAD || (cfg_check_ovr && ovr)) begin
        st = ST_REJECT;
        if (attempt_cnt != 8'hff) attempt_cnt++;
      end else begin
        f = int'(cfg_fuzz);
        g = int'(cfg_one_g);
        for (int i = 0; i < 3; i++) begin
          sens[i] = decode_axis(raws[i], cfg_range);
        end
        for (int i = 0; i < 3; i++) begin
          c = cfg_map[i];
          board[i] = (c > MAP_LAST) ? 0 : (c[0] ? -sens[c >> 1] : sens[c >> 1]);
        end
        if (board[0] < f && board[0] > -f && board[1] < f && board[1] > -f &&
            board[2] < g + f && board[2] > g - f) begin
          st = ST_DONE;
          calibrating = 1'b0;
        end else begin
          st = ST_UPDATED;
          if (attempt_cnt != 8'hff) attempt_cnt++;
          sums[0] = sums[0] - acc_t'(board[0]);
          sums[1] = sums[1] - acc_t'(board[1]);
          sums[2] = sums[2] + acc_t'(g - board[2]);
          // later map registers win when two name the same sensor axis
          for (int i = 0; i < 3; i++) begin
            c = cfg_map[i];
            if (c <= MAP_LAST) begin
              unmapped[c >> 1] = c[0] ? acc_t'(16'd0 - sums[i]) : sums[i];
            end
          end
        end
      end
    end
    res.status = st;
    res.off_x = unmapped[0][OffW-1:0];
    res.off_y = unmapped[1][OffW-1:0];
    res.off_z = unmapped[2][OffW-1:0];
    res.attempts = attempt_cnt;
    offsets_due.push_back(res);
  endtask

  task automatic send_sample(input logic start, input logic ready, input logic ovr,
                             input logic [9:0] x, input logic [9:0] y,
                             input logic [9:0] z);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_req_i <= start;
    data_ready_i <= ready;
    overrun_i <= ovr;
    raw_x_i <= x;
    raw_y_i <= y;
    raw_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    calibrate_step(start, ready, ovr, x, y, z);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (offsets_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [8:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_RANGE:   cfg_range = range_e'(value[1:0]);
      CFG_MAP_X:   cfg_map[0] = value[2:0];
      CFG_MAP_Y:   cfg_map[1] = value[2:0];
      CFG_MAP_Z:   cfg_map[2] = value[2:0];
      CFG_OVERRUN: cfg_check_ovr = value[0];
      CFG_FUZZ:    cfg_fuzz = value[6:0];
      CFG_ONE_G:   cfg_one_g = value[8:0];
      CFG_MAX_ATT: cfg_max_att = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // encode a sensor-frame value as register bits for the current range
  function automatic logic [9:0] to_raw(int v);
    if (cfg_range == RANGE_8G) begin
      if (v > 511) v = 511;
      if (v < -512) v = -512;
      return 10'(v);
    end
    if (cfg_range == RANGE_4G) v = v / 2;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return {2'($urandom), 8'(v)};
  endfunction

  task automatic random_setup();
    int perm [3];
    int j;
    int tmp;
    int lim;
    map_t code;
    drain();
    write_reg(CFG_RANGE,
              9'(($urandom_range(19) == 0) ? int'(RANGE_BAD) : int'($urandom_range(2))));
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < 3; i++) begin
      code = map_t'(2 * perm[i] + $urandom_range(1));
      if ($urandom_range(99) < 12) code = map_t'($urandom_range(7));
      write_reg(cfg_idx_e'(CFG_MAP_X + i), 9'(code));
    end
    write_reg(CFG_OVERRUN, 9'($urandom_range(1)));
    case ($urandom_range(9))
      0: write_reg(CFG_FUZZ, 1);
      1: write_reg(CFG_FUZZ, 64);
      2: write_reg(CFG_FUZZ, 0);
      3: write_reg(CFG_FUZZ, 127);
      default: write_reg(CFG_FUZZ, 9'($urandom_range(12, 1)));
    endcase
    lim = (cfg_range == RANGE_8G) ? 511 : (cfg_range == RANGE_2G) ? 127 : 254;
    write_reg(CFG_ONE_G, 9'(($urandom_range(15) == 0) ? 511 : $urandom_range(lim)));
    case ($urandom_range(29))
      0: write_reg(CFG_MAX_ATT, 254);
      1: write_reg(CFG_MAX_ATT, 255);
      default: write_reg(CFG_MAX_ATT, 9'($urandom_range(30)));
    endcase
  endtask

  // mostly readings near the target attitude, so that calibrations converge
  task automatic random_item();
    int spread;
    int t [3];
    int sv [3];
    map_t c;
    logic [9:0] raw [3];
    logic start;
    logic ready;
    logic ovr;
    start = calibrating ? ($urandom_range(99) < 6) : ($urandom_range(99) < 85);
    ready = ($urandom_range(99) < 94);
    ovr = ($urandom_range(99) < 10);
    if ($urandom_range(99) < 78) begin
      spread = int'(cfg_fuzz) + 2;
      t[0] = int'($urandom_range(2 * spread)) - spread;
      t[1] = int'($urandom_range(2 * spread)) - spread;
      t[2] = int'(cfg_one_g) + int'($urandom_range(2 * spread)) - spread;
      sv = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
        c = cfg_map[i];
        if (c <= MAP_LAST) sv[c >> 1] = c[0] ? -t[i] : t[i];
      end
      for (int k = 0; k < 3; k++) raw[k] = to_raw(sv[k]);
    end else begin
      for (int k = 0; k < 3; k++) raw[k] = 10'($urandom);
    end
    send_sample(start, ready, ovr, raw[0], raw[1], raw[2]);
  endtask

  task automatic test_default_config();
    send_sample(0, 1, 0, 10'h000, 10'h000, 10'h000);
    send_sample(1, 1, 0, 10'h000, 10'h000, 10'h0e0);
    send_sample(1, 0, 0, 10'h000, 10'h000, 10'h000);
    send_sample(0, 1, 1, 10'h000, 10'h000, 10'h0e0);
    send_sample(0, 1, 0, 10'h07f, 10'h080, 10'h3ff);
    send_sample(0, 1, 0, 10'h3ff, 10'h200, 10'h000);
    send_sample(0, 1, 0, 10'h155, 10'h2aa, 10'h0e0);
    send_sample(0, 1, 0, 10'h001, 10'h3ff, 10'h0e0);
    drain();
  endtask

  task automatic test_range_modes();
    write_reg(CFG_RANGE, 9'(RANGE_8G));
    write_reg(CFG_FUZZ, 5);
    write_reg(CFG_ONE_G, 100);
    send_sample(1, 1, 0, 10'd4, 10'h3fc, 10'h398);
    send_sample(1, 1, 0, 10'd5, 10'd0, 10'h398);
    send_sample(0, 1, 0, 10'h1ff, 10'h200, 10'h3ff);
    send_sample(0, 1, 0, 10'h3fb, 10'h001, 10'h39d);
    drain();
    write_reg(CFG_RANGE, 9'(RANGE_2G));
    send_sample(1, 1, 0, 10'h3ff, 10'h100, 10'h39c);
    send_sample(1, 1, 0, 10'h080, 10'h07f, 10'h300);
    drain();
    write_reg(CFG_RANGE, 9'(RANGE_BAD));
    send_sample(1, 1, 0, 10'h000, 10'h000, 10'h000);
    drain();
    write_reg(CFG_RANGE, 9'(RANGE_4G));
  endtask

  task automatic test_map_and_window();
    write_reg(CFG_MAP_X, 9'd6);
    write_reg(CFG_MAP_Y, 9'd7);
    write_reg(CFG_MAP_Z, 9'(MAP_POS_Z));
    send_sample(1, 1, 0, 10'h010, 10'h020, 10'h040);
    drain();
    write_reg(CFG_MAP_X, 9'(MAP_NEG_X));
    write_reg(CFG_MAP_Y, 9'(MAP_NEG_X));
    write_reg(CFG_MAP_Z, 9'(MAP_NEG_Y));
    write_reg(CFG_OVERRUN, 0);
    send_sample(0, 1, 1, 10'h011, 10'h022, 10'h033);
    drain();
    write_reg(CFG_MAP_X, 9'(MAP_POS_X));
    write_reg(CFG_MAP_Y, 9'(MAP_POS_Y));
    write_reg(CFG_MAP_Z, 9'(MAP_NEG_Z));
    write_reg(CFG_FUZZ, 0);
    write_reg(CFG_ONE_G, 0);
    send_sample(1, 1, 0, 10'h000, 10'h000, 10'h000);
    drain();
    write_reg(CFG_FUZZ, 127);
    write_reg(CFG_ONE_G, 511);
    send_sample(1, 1, 0, 10'h03f, 10'h3c1, 10'h381);
    drain();
    write_reg(CFG_RANGE, 9'(RANGE_8G));
    send_sample(0, 1, 0, 10'd126, 10'h382, 10'h20c);
    drain();
    write_reg(CFG_OVERRUN, 1);
    write_reg(CFG_FUZZ, 3);
    write_reg(CFG_ONE_G, 64);
    write_reg(CFG_RANGE, 9'(RANGE_4G));
  endtask

  task automatic test_attempt_limit();
    write_reg(CFG_MAX_ATT, 0);
    send_sample(1, 0, 0, 10'h000, 10'h000, 10'h000);
    send_sample(0, 1, 0, 10'h000, 10'h000, 10'h000);
    send_sample(0, 1, 0, 10'h000, 10'h000, 10'h000);
    drain();
    // count saturates and never exceeds the top limit
    write_reg(CFG_MAX_ATT, 255);
    send_sample(1, 0, 0, 10'h000, 10'h000, 10'h000);
    repeat (259) send_sample(0, 0, 1, 10'($urandom), 10'($urandom), 10'($urandom));
    drain();
    write_reg(CFG_MAX_ATT, 254);
    send_sample(0, 1, 0, 10'h000, 10'h000, 10'h000);
    drain();
    write_reg(CFG_MAX_ATT, 20);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int n_items, input bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n % 50 == 0) random_setup();
      if (with_hold && n == 25) hold_off = 60;
      if (n == n_items / 2 + 10) drain();
      random_item();
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    start_req_i = 1'b0;
    data_ready_i = 1'b0;
    overrun_i = 1'b0;
    raw_x_i = '0;
    raw_y_i = '0;
    raw_z_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_config();
    test_range_modes();
    test_map_and_window();
    test_attempt_limit();
    test_random_phase(29, 47, 155, 1'b1);
    test_random_phase(47, 29, 155, 1'b0);
    test_random_phase(0, 0, 155, 1'b0);

    drain();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && offsets_due.size() == 0) begin
      $display("accel_offset_calibration: match");
    end else begin
      $display("accel_offset_calibration: mismatch");
    end
    $finish;
  end

endmodule
